### sv/sm83alu_pkg.sv
// Shared types and operation codes for the SM83 8-bit ALU.
`timescale 1ns / 1ps

package sm83alu_pkg;

   // operation groups
   localparam logic [2:0] OP_ALU    = 3'd0;
   localparam logic [2:0] OP_ROT    = 3'd1;
   localparam logic [2:0] OP_ACC    = 3'd2;
   localparam logic [2:0] OP_BIT    = 3'd3;
   localparam logic [2:0] OP_RES    = 3'd4;
   localparam logic [2:0] OP_SET    = 3'd5;
   localparam logic [2:0] OP_INC    = 3'd6;
   localparam logic [2:0] OP_DEC    = 3'd7;

   // alu group
   localparam logic [2:0] ALU_ADD   = 3'd0;
   localparam logic [2:0] ALU_ADC   = 3'd1;
   localparam logic [2:0] ALU_SUB   = 3'd2;
   localparam logic [2:0] ALU_SBC   = 3'd3;
   localparam logic [2:0] ALU_AND   = 3'd4;
   localparam logic [2:0] ALU_XOR   = 3'd5;
   localparam logic [2:0] ALU_OR    = 3'd6;
   localparam logic [2:0] ALU_CP    = 3'd7;

   // rotate/shift group
   localparam logic [2:0] ROT_RLC   = 3'd0;
   localparam logic [2:0] ROT_RRC   = 3'd1;
   localparam logic [2:0] ROT_RL    = 3'd2;
   localparam logic [2:0] ROT_RR    = 3'd3;
   localparam logic [2:0] ROT_SLA   = 3'd4;
   localparam logic [2:0] ROT_SRA   = 3'd5;
   localparam logic [2:0] ROT_SWAP  = 3'd6;
   localparam logic [2:0] ROT_SRL   = 3'd7;

   // accumulator group (0..3 are the A-register rotates)
   localparam logic [2:0] ACC_DAA   = 3'd4;
   localparam logic [2:0] ACC_CPL   = 3'd5;
   localparam logic [2:0] ACC_SCF   = 3'd6;
   localparam logic [2:0] ACC_CCF   = 3'd7;

   // flag bit positions
   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   // decimal adjust constants
   localparam logic [7:0] DAA_LIMIT    = 8'h99;
   localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
   localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
   localparam logic [3:0] DAA_LO_LIMIT = 4'h9;

   typedef struct packed {
      logic [2:0] op;
      logic [2:0] func;
      logic [7:0] acc;
      logic [7:0] operand;
      logic [3:0] flags_in;
   } req_type;

   typedef struct packed {
      logic [7:0] result;
      logic [3:0] flags_out;
   } rsp_type;

endpackage

### sv/sm83alu_core.sv
// Combinational SM83 ALU datapath: value and Z/N/H/C flags for one request.
`timescale 1ns / 1ps

module sm83alu_core (
   input  sm83alu_pkg::req_type req,
   output sm83alu_pkg::rsp_type rsp
);

   // rotate/shift unit, shared by the CB group and the A-register rotates
   function automatic logic [8:0] rot_fn(input logic [2:0] f, input logic [7:0] v,
                                         input logic cin);
      logic [8:0] r;   // {carry out, value}
      case (f)
         sm83alu_pkg::ROT_RLC:  r = {v[7], v[6:0], v[7]};
         sm83alu_pkg::ROT_RRC:  r = {v[0], v[0], v[7:1]};
         sm83alu_pkg::ROT_RL:   r = {v[7], v[6:0], cin};
         sm83alu_pkg::ROT_RR:   r = {v[0], cin, v[7:1]};
         sm83alu_pkg::ROT_SLA:  r = {v[7], v[6:0], 1'b0};
         sm83alu_pkg::ROT_SRA:  r = {v[0], v[7], v[7:1]};
         sm83alu_pkg::ROT_SWAP: r = {1'b0, v[3:0], v[7:4]};
         default:               r = {v[0], 1'b0, v[7:1]};
      endcase
      return r;
   endfunction

   logic       zin, nin, hin, cin;
   logic [8:0] sum9, diff9, rot_op, rot_acc;
   logic [4:0] hsum5, hdiff5;
   logic       alu_c;
   logic [7:0] bit_mask;
   logic [7:0] daa_v;
   logic       daa_c;
   logic [7:0] inc_v, dec_v;

   assign zin = req.flags_in[sm83alu_pkg::FLAG_Z];
   assign nin = req.flags_in[sm83alu_pkg::FLAG_N];
   assign hin = req.flags_in[sm83alu_pkg::FLAG_H];
   assign cin = req.flags_in[sm83alu_pkg::FLAG_C];

   // carry in only for ADC / SBC
   assign alu_c  = ((req.func == sm83alu_pkg::ALU_ADC) || (req.func == sm83alu_pkg::ALU_SBC))
                   ? cin : 1'b0;
   assign sum9   = {1'b0, req.acc} + {1'b0, req.operand} + {8'd0, alu_c};
   assign hsum5  = {1'b0, req.acc[3:0]} + {1'b0, req.operand[3:0]} + {4'd0, alu_c};
   // bit 8 / bit 4 of the differences is the borrow
   assign diff9  = {1'b0, req.acc} - {1'b0, req.operand} - {8'd0, alu_c};
   assign hdiff5 = {1'b0, req.acc[3:0]} - {1'b0, req.operand[3:0]} - {4'd0, alu_c};

   assign rot_op  = rot_fn(req.func, req.operand, cin);
   assign rot_acc = rot_fn(req.func, req.acc, cin);

   assign bit_mask = 8'd1 << req.func;
   assign inc_v    = req.operand + 8'd1;
   assign dec_v    = req.operand - 8'd1;

   // decimal adjust; low nibble test is unaffected by the 0x60 step
   always_comb begin
      daa_v = req.acc;
      daa_c = cin;
      if (!nin) begin
         if (cin || (req.acc > sm83alu_pkg::DAA_LIMIT)) begin
            daa_v = daa_v + sm83alu_pkg::DAA_HI_ADJ;
            daa_c = 1'b1;
         end
         if (hin || (req.acc[3:0] > sm83alu_pkg::DAA_LO_LIMIT)) begin
            daa_v = daa_v + sm83alu_pkg::DAA_LO_ADJ;
         end
      end else begin
         if (cin) begin
            daa_v = daa_v - sm83alu_pkg::DAA_HI_ADJ;
         end
         if (hin) begin
            daa_v = daa_v - sm83alu_pkg::DAA_LO_ADJ;
         end
      end
   end

   always_comb begin
      rsp = '0;
      case (req.op)
         sm83alu_pkg::OP_ALU: begin
            case (req.func)
               sm83alu_pkg::ALU_ADD, sm83alu_pkg::ALU_ADC: begin
                  rsp.result    = sum9[7:0];
                  rsp.flags_out = {sum9[7:0] == 8'd0, 1'b0, hsum5[4], sum9[8]};
               end
               sm83alu_pkg::ALU_SUB, sm83alu_pkg::ALU_SBC, sm83alu_pkg::ALU_CP: begin
                  rsp.result    = (req.func == sm83alu_pkg::ALU_CP) ? req.acc : diff9[7:0];
                  rsp.flags_out = {diff9[7:0] == 8'd0, 1'b1, hdiff5[4], diff9[8]};
               end
               sm83alu_pkg::ALU_AND: begin
                  rsp.result    = req.acc & req.operand;
                  rsp.flags_out = {(req.acc & req.operand) == 8'd0, 3'b010};
               end
               sm83alu_pkg::ALU_XOR: begin
                  rsp.result    = req.acc ^ req.operand;
                  rsp.flags_out = {(req.acc ^ req.operand) == 8'd0, 3'b000};
               end
               default: begin
                  rsp.result    = req.acc | req.operand;
                  rsp.flags_out = {(req.acc | req.operand) == 8'd0, 3'b000};
               end
            endcase
         end
         sm83alu_pkg::OP_ROT: begin
            rsp.result    = rot_op[7:0];
            rsp.flags_out = {rot_op[7:0] == 8'd0, 2'b00, rot_op[8]};
         end
         sm83alu_pkg::OP_ACC: begin
            case (req.func)
               sm83alu_pkg::ACC_DAA: begin
                  rsp.result    = daa_v;
                  rsp.flags_out = {daa_v == 8'd0, nin, 1'b0, daa_c};
               end
               sm83alu_pkg::ACC_CPL: begin
                  rsp.result    = ~req.acc;
                  rsp.flags_out = {zin, 2'b11, cin};
               end
               sm83alu_pkg::ACC_SCF: begin
                  rsp.result    = req.acc;
                  rsp.flags_out = {zin, 3'b001};
               end
               sm83alu_pkg::ACC_CCF: begin
                  rsp.result    = req.acc;
                  rsp.flags_out = {zin, 2'b00, ~cin};
               end
               default: begin
                  // RLCA/RRCA/RLA/RRA: Z forced low
                  rsp.result    = rot_acc[7:0];
                  rsp.flags_out = {3'b000, rot_acc[8]};
               end
            endcase
         end
         sm83alu_pkg::OP_BIT: begin
            rsp.result    = req.operand;
            rsp.flags_out = {~req.operand[req.func], 2'b01, cin};
         end
         sm83alu_pkg::OP_RES: begin
            rsp.result    = req.operand & ~bit_mask;
            rsp.flags_out = req.flags_in;
         end
         sm83alu_pkg::OP_SET: begin
            rsp.result    = req.operand | bit_mask;
            rsp.flags_out = req.flags_in;
         end
         sm83alu_pkg::OP_INC: begin
            rsp.result    = inc_v;
            rsp.flags_out = {inc_v == 8'd0, 1'b0, req.operand[3:0] == 4'hF, cin};
         end
         default: begin
            rsp.result    = dec_v;
            rsp.flags_out = {dec_v == 8'd0, 1'b1, req.operand[3:0] == 4'h0, cin};
         end
      endcase
   end

endmodule

### sv/sm83_8bit_alu_with_flags_unit.sv
// Top level of the SM83 8-bit ALU: input register, ALU datapath, result register.
`timescale 1ns / 1ps

// SM83 8-bit ALU with Z/N/H/C flags. A request carries the operation group
// (op), the sub-operation or bit index (func), the accumulator, the operand and
// the current flags; each request yields exactly one response with the new value
// and new flags. The unit is a two-register pipeline: requests land in an input
// register, the whole ALU function is evaluated combinationally from that
// register, and the outcome is captured in the response register. Throughput is
// one request per clock while the response side is ready. rsp_valid rises when
// the response register captures the outcome, never in the accepting cycle.
// Backpressure on rsp_ready propagates combinationally to req_ready, so with the
// response side always ready the unit never stalls; with it stalled, two requests
// are held (one per register) before req_ready drops. There is no state across
// requests and nothing to configure; reset only clears the valid bits.

module sm83_8bit_alu_with_flags_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_op,
   input  logic [2:0] req_func,
   input  logic [7:0] req_acc,
   input  logic [7:0] req_operand,
   input  logic [3:0] req_flags_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_result,
   output logic [3:0] rsp_flags_out
);

   logic                 s1_valid_ff, s1_valid_in;
   sm83alu_pkg::req_type s1_req_ff;
   sm83alu_pkg::rsp_type alu_rsp;
   logic                 out_valid_ff, out_valid_in;
   sm83alu_pkg::rsp_type out_rsp_ff;
   logic                 out_load;
   logic                 req_take;

   // response register loads when it is empty or being drained this cycle
   assign out_load  = !out_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || out_load;
   assign req_take  = req_valid && req_ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !out_load);
   assign out_valid_in = out_load ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_req_ff <= '{op: req_op, func: req_func, acc: req_acc,
                        operand: req_operand, flags_in: req_flags_in};
      end
      if (out_load && s1_valid_ff) begin
         out_rsp_ff <= alu_rsp;
      end
   end

   sm83alu_core u_core (
      .req (s1_req_ff),
      .rsp (alu_rsp)
   );

   assign rsp_valid     = out_valid_ff;
   assign rsp_result    = out_rsp_ff.result;
   assign rsp_flags_out = out_rsp_ff.flags_out;

   // a held request is not dropped while the response side is stalled
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_load && !req_take |=> s1_valid_ff)
      else $error("input stage lost a request under backpressure");

   // an accepted request always occupies the input stage next cycle
   a_s1_fill: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted request not captured");

   // a new response only appears when the input stage held something
   a_out_src: assert property (@(posedge clock) disable iff (reset)
      out_load && !s1_valid_ff |=> !out_valid_ff)
      else $error("response produced with no request behind it");

   // an empty input stage never backpressures
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ready)
      else $error("req_ready low with empty input stage");

endmodule
